FILE: src/sm4ks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 key schedule package
// S-box table, FK system constants, CK generation and the round key mix.
// ----------------------------------------------------------------------------
package sm4ks_pkg;

	localparam int unsigned ROUNDS = 32;
	localparam int unsigned RND_W  = $clog2(ROUNDS);

	typedef logic [31:0]      word_t;
	typedef logic [RND_W-1:0] rnd_t;

	localparam word_t FK0 = 32'hA3B1BAC6;
	localparam word_t FK1 = 32'h56AA3350;
	localparam word_t FK2 = 32'h677D9197;
	localparam word_t FK3 = 32'hB27022DC;

	localparam int unsigned ROT_A = 13;
	localparam int unsigned ROT_B = 23;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
		8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
		8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
		8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
		8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
		8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
		8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
		8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
		8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
		8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
		8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
		8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
		8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
		8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
		8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
		8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
		8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// CK byte j of round i is (4i+j)*7 mod 256, byte 0 most significant
	function automatic word_t ck_word(input rnd_t i);
		word_t            w;
		logic [RND_W+1:0] idx;
		logic [RND_W+4:0] prod;
		begin
			w = '0;
			for (int j = 0; j < 4; j++) begin
				idx  = {i, 2'(j)};
				prod = (RND_W+5)'(idx) * (RND_W+5)'(7);
				w[31-8*j -: 8] = prod[7:0];
			end
			return w;
		end
	endfunction

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

`default_nettype wire

FILE: src/sm4ks_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 key schedule round unit
// One key round: XOR of the three newest words and CK, byte S-box, linear
// map B ^ (B<<<13) ^ (B<<<23), XOR into the oldest word.
// ----------------------------------------------------------------------------
module sm4ks_round (
	input  wire sm4ks_pkg::word_t win0,
	input  wire sm4ks_pkg::word_t win1,
	input  wire sm4ks_pkg::word_t win2,
	input  wire sm4ks_pkg::word_t win3,
	input  wire sm4ks_pkg::rnd_t  rnd,
	output sm4ks_pkg::word_t      new_word
);
	import sm4ks_pkg::*;

	word_t mix_in;
	word_t sub;

	always_comb begin
		mix_in = win1 ^ win2 ^ win3 ^ ck_word(rnd);
		for (int b = 0; b < 4; b++) begin
			sub[8*b +: 8] = SBOX[mix_in[8*b +: 8]];
		end
		new_word = win0 ^ sub ^ rotl(sub, ROT_A) ^ rotl(sub, ROT_B);
	end

endmodule

`default_nettype wire

FILE: src/sm4_key_schedule.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SM4 key schedule
// Expands one 128-bit master key into 32 round keys, one round per cycle while the output does not stall.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload
// in      | in_valid, in_stall | key_word_0..key_word_3 (key_word_0 is MSW)
// out     | out_valid,out_stall| round_key, round_number, final_key
//
// One key beat in gives 32 round key beats out; the shared round unit runs
// one round per cycle while the output does not stall.
// in_stall is high while a key is being expanded; the next key may enter
// while the last round key still waits in the output register.
// Output stall holds the round sequencer. Reset clears control state only.
// ----------------------------------------------------------------------------
module sm4_key_schedule (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sm4ks_pkg::word_t  key_word_0,
	input  wire sm4ks_pkg::word_t  key_word_1,
	input  wire sm4ks_pkg::word_t  key_word_2,
	input  wire sm4ks_pkg::word_t  key_word_3,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output sm4ks_pkg::word_t       round_key,
	output sm4ks_pkg::rnd_t        round_number,
	output logic                   final_key
);
	import sm4ks_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;
	localparam rnd_t LAST_RND = RND_W'(ROUNDS - 1);

	logic  state_q;
	rnd_t  rnd_q;
	word_t win_q [4];
	logic  out_valid_q;
	word_t round_key_q;
	rnd_t  round_number_q;
	logic  final_key_q;

	logic  in_acc;
	logic  advance;
	word_t new_word;

	sm4ks_round u_round (
		.win0     (win_q[0]),
		.win1     (win_q[1]),
		.win2     (win_q[2]),
		.win3     (win_q[3]),
		.rnd      (rnd_q),
		.new_word (new_word)
	);

	assign in_stall = (state_q == ST_RUN);
	assign in_acc   = in_valid && !in_stall;
	assign advance  = (state_q == ST_RUN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= ST_RUN;
				rnd_q   <= '0;
			end else if (advance) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == LAST_RND) begin
					state_q <= ST_IDLE;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_q[0] <= key_word_0 ^ FK0;
			win_q[1] <= key_word_1 ^ FK1;
			win_q[2] <= key_word_2 ^ FK2;
			win_q[3] <= key_word_3 ^ FK3;
		end else if (advance) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			win_q[3] <= new_word;
		end
		if (advance) begin
			round_key_q    <= new_word;
			round_number_q <= rnd_q;
			final_key_q    <= (rnd_q == LAST_RND);
		end
	end

	assign out_valid    = out_valid_q;
	assign round_key    = round_key_q;
	assign round_number = round_number_q;
	assign final_key    = final_key_q;

	// key beat starts a run at round zero
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN) && (rnd_q == '0))
		else $error("run did not start at round zero");

	// last round releases the input side
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (rnd_q == LAST_RND) |=> (state_q == ST_IDLE) && final_key_q)
		else $error("run did not end after last round");

	// final flag only on the last round number
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && final_key_q |-> (round_number_q == LAST_RND))
		else $error("final flag on wrong round");

	// no round beat is produced outside a run
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && out_valid_q && !out_stall |=> !out_valid_q)
		else $error("output beat while idle");

endmodule

`default_nettype wire
